// ----- src/tcfo_pkg.sv -----
// ----------------------------------------------------------------------------
// tcfo_pkg
// Shared types and constants for the two-class FIFO with oldest-first dequeue.
// ----------------------------------------------------------------------------
package tcfo_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_WIDTH   = 32;
	localparam int STAMP_W     = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_ENQ = 2'd0,
		ACT_DEQ = 2'd1,
		ACT_ANY = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [TAG_WIDTH-1:0] tag;
		logic [STAMP_W-1:0]   stamp;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	typedef struct packed {
		status_t            status;
		logic               out_kind;
		logic [31:0]        out_tag;
		logic [STAMP_W-1:0] arrival;
	} result_t;

endpackage

// ----- src/two_class_fifo_oldest_first.sv -----
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two class queues sharing an arrival counter; dequeue takes a named class, or the oldest head for ACT_ANY.
//
//   channel | handshake          | payload
//   in      | in_valid, in_ready | action, kind, tag
//   out     | out_valid,out_ready| status, out_kind, out_tag, arrival
//
// A request is captured in an input register, decided against the queue
// heads and counts while it sits there, and its result lands in an output
// register; one request is accepted per cycle unless the output stalls.
// Queue state is updated when a request moves into the output register.
// Reset empties both queues and clears the arrival counter.
// A stalled output holds the input register, which then holds off in_ready.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic        kind,
	input  logic [31:0] tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        out_kind,
	output logic [31:0] out_tag,
	output logic [31:0] arrival
);

	logic                         valid_s1;
	logic [1:0]                   action_s1;
	logic                         kind_s1;
	logic [31:0]                  tag_s1;
	logic                         out_valid_q;
	tcfo_pkg::result_t            res_q;
	logic [tcfo_pkg::STAMP_W-1:0] counter_q;

	logic                         advance;
	tcfo_pkg::queue_ctrl_t        sel_ctrl0;
	tcfo_pkg::queue_ctrl_t        sel_ctrl1;
	tcfo_pkg::queue_ctrl_t        ctrl0;
	tcfo_pkg::queue_ctrl_t        ctrl1;
	tcfo_pkg::queue_stat_t        stat0;
	tcfo_pkg::queue_stat_t        stat1;
	tcfo_pkg::entry_t             head0;
	tcfo_pkg::entry_t             head1;
	tcfo_pkg::entry_t             wr_entry;
	logic                         sel_adv;
	logic                         counter_adv;
	tcfo_pkg::result_t            res;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			kind_s1   <= kind;
			tag_s1    <= tag;
		end
	end

	tcfo_select u_select (
		.action      (action_s1),
		.kind        (kind_s1),
		.tag         (tag_s1),
		.counter     (counter_q),
		.stat0       (stat0),
		.stat1       (stat1),
		.head0       (head0),
		.head1       (head1),
		.ctrl0       (sel_ctrl0),
		.ctrl1       (sel_ctrl1),
		.wr_entry    (wr_entry),
		.counter_adv (sel_adv),
		.res         (res)
	);

	assign ctrl0       = advance ? sel_ctrl0 : '0;
	assign ctrl1       = advance ? sel_ctrl1 : '0;
	assign counter_adv = advance && sel_adv;

	tcfo_queue u_queue0 (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl0),
		.wr_entry   (wr_entry),
		.head_entry (head0),
		.stat       (stat0)
	);

	tcfo_queue u_queue1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl1),
		.wr_entry   (wr_entry),
		.head_entry (head1),
		.stat       (stat1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (counter_adv) begin
				counter_q <= wr_entry.stamp;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign out_kind  = res_q.out_kind;
	assign out_tag   = res_q.out_tag;
	assign arrival   = res_q.arrival;

	a_pop0_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl0.pop |-> !stat0.empty)
		else $error("pop from empty first queue");

	a_pop1_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl1.pop |-> !stat1.empty)
		else $error("pop from empty second queue");

	a_counter_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!counter_adv |=> $stable(counter_q))
		else $error("arrival counter moved without an enqueue");

	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.status == tcfo_pkg::ST_FULL) |-> !(ctrl0.push || ctrl1.push))
		else $error("request reported full but was stored");

endmodule

// ----- src/tcfo_queue.sv -----
// ----------------------------------------------------------------------------
// tcfo_queue
// One class queue: circular entry store with head, tail and fill count.
// ----------------------------------------------------------------------------
module tcfo_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcfo_pkg::queue_ctrl_t ctrl,
	input  tcfo_pkg::entry_t     wr_entry,
	output tcfo_pkg::entry_t     head_entry,
	output tcfo_pkg::queue_stat_t stat
);

	tcfo_pkg::entry_t              mem_q [tcfo_pkg::QUEUE_DEPTH];
	tcfo_pkg::entry_t              head_data_q;
	logic [tcfo_pkg::IDX_W-1:0]    head_q;
	logic [tcfo_pkg::IDX_W-1:0]    tail_q;
	logic [tcfo_pkg::CNT_W-1:0]    count_q;
	logic [tcfo_pkg::IDX_W-1:0]    head_next;
	logic                          load_wr;

	localparam logic [tcfo_pkg::IDX_W-1:0] LAST_IDX =
		tcfo_pkg::IDX_W'(tcfo_pkg::QUEUE_DEPTH - 1);
	localparam logic [tcfo_pkg::CNT_W-1:0] FULL_CNT = tcfo_pkg::CNT_W'(tcfo_pkg::QUEUE_DEPTH);
	localparam logic [tcfo_pkg::CNT_W-1:0] ONE_CNT  = tcfo_pkg::CNT_W'(1);

	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

	// The new entry becomes the head when it lands in a queue that is, or
	// is about to be, empty.
	assign load_wr = ctrl.push && ((count_q == '0) || (ctrl.pop && count_q == ONE_CNT));

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[tail_q] <= wr_entry;
		end
		if (load_wr) begin
			head_data_q <= wr_entry;
		end else if (ctrl.pop) begin
			head_data_q <= mem_q[head_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
			end
			if (ctrl.pop) begin
				head_q <= head_next;
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_entry = head_data_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FULL_CNT);

endmodule

// ----- src/tcfo_select.sv -----
// ----------------------------------------------------------------------------
// tcfo_select
// Decides the queue operation for one request and forms its result.
// ----------------------------------------------------------------------------
module tcfo_select (
	input  logic [1:0]                     action,
	input  logic                           kind,
	input  logic [31:0]                    tag,
	input  logic [tcfo_pkg::STAMP_W-1:0]   counter,
	input  tcfo_pkg::queue_stat_t          stat0,
	input  tcfo_pkg::queue_stat_t          stat1,
	input  tcfo_pkg::entry_t               head0,
	input  tcfo_pkg::entry_t               head1,
	output tcfo_pkg::queue_ctrl_t          ctrl0,
	output tcfo_pkg::queue_ctrl_t          ctrl1,
	output tcfo_pkg::entry_t               wr_entry,
	output logic                           counter_adv,
	output tcfo_pkg::result_t              res
);

	logic [tcfo_pkg::STAMP_W-1:0] next_stamp;
	logic [tcfo_pkg::STAMP_W-1:0] diff;
	logic                         take_first;
	logic                         do_pop;

	assign next_stamp     = counter + 1'b1;
	assign diff           = head0.stamp - head1.stamp;
	assign wr_entry.tag   = tag[tcfo_pkg::TAG_WIDTH-1:0];
	assign wr_entry.stamp = next_stamp;

	always_comb begin
		ctrl0       = '0;
		ctrl1       = '0;
		counter_adv = 1'b0;
		res         = '0;
		res.status  = tcfo_pkg::ST_OK;
		take_first  = 1'b0;
		do_pop      = 1'b0;
		case (tcfo_pkg::action_t'(action))
			tcfo_pkg::ACT_ENQ: begin
				if ((kind == 1'b0) ? stat0.full : stat1.full) begin
					res.status = tcfo_pkg::ST_FULL;
				end else begin
					ctrl0.push  = (kind == 1'b0);
					ctrl1.push  = (kind == 1'b1);
					counter_adv = 1'b1;
					res.arrival = next_stamp;
				end
			end
			tcfo_pkg::ACT_DEQ: begin
				take_first = (kind == 1'b0);
				do_pop     = 1'b1;
			end
			tcfo_pkg::ACT_ANY: begin
				do_pop = 1'b1;
				if (stat0.empty) begin
					take_first = 1'b0;
				end else if (stat1.empty) begin
					take_first = 1'b1;
				end else begin
					take_first = diff[tcfo_pkg::STAMP_W-1];
				end
			end
			default: begin
				res.status = tcfo_pkg::ST_OK;
			end
		endcase
		if (do_pop) begin
			if (take_first ? stat0.empty : stat1.empty) begin
				res.status = tcfo_pkg::ST_EMPTY;
			end else if (take_first) begin
				ctrl0.pop    = 1'b1;
				res.out_kind = 1'b0;
				res.out_tag  = 32'(head0.tag);
				res.arrival  = head0.stamp;
			end else begin
				ctrl1.pop    = 1'b1;
				res.out_kind = 1'b1;
				res.out_tag  = 32'(head1.tag);
				res.arrival  = head1.stamp;
			end
		end
	end

endmodule
